FILE: sv/largest_differencing_residue_assert.svh
// assertion macros shared by the largest differencing residue rtl
// no dependencies; included by the modules that carry assertions
`ifndef LARGEST_DIFFERENCING_RESIDUE_ASSERT_SVH
`define LARGEST_DIFFERENCING_RESIDUE_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, switched off while reset is held
`define LDR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also active through reset
`define LDR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LDR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LDR_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/ldr_pkg.sv
// shared types and defaults for the largest differencing residue block
// no dependencies; used by ldr_ctrl, ldr_dpath and the top level
`default_nettype none

package ldr_pkg;

    // default sizes of the heap store and of one number
    localparam int DEF_MAX_ITEMS  = 128;
    localparam int DEF_VALUE_BITS = 60;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BLD_CHK,
        S_BLD_RD,
        S_BLD_V,
        S_DOWN,
        S_EXT_CHK,
        S_EXT_RD,
        S_EXT_V,
        S_REP_RD,
        S_REP_V,
        S_FIN_RD,
        S_FIN_V
    } ldr_state_t;

    // datapath commands, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BLD_RD,
        OP_BLD_V,
        OP_EXT_RD,
        OP_EXT_V,
        OP_TOP_RD,
        OP_REP_V,
        OP_DOWN,
        OP_OUT
    } ldr_op_t;

    // datapath status towards the controller
    typedef struct packed {
        logic down_done;
        logic bld_more;
        logic size_gt1;
        logic out_free;
    } ldr_status_t;

endpackage

`default_nettype wire

FILE: sv/ldr_ctrl.sv
// controller state machine: sequences load, heap build, differencing and output
// depends on ldr_pkg and largest_differencing_residue_assert.svh
`default_nettype none
`include "largest_differencing_residue_assert.svh"

module ldr_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tlast,
    output logic                     s_tready,
    input  wire ldr_pkg::ldr_status_t status,
    output ldr_pkg::ldr_op_t         op
);

    ldr_pkg::ldr_state_t state_reg, state_next;
    ldr_pkg::ldr_state_t ret_reg, ret_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ldr_pkg::S_IDLE;
            ret_reg   <= ldr_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // next state; ret_reg remembers where a sift-down pass goes back to
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ldr_pkg::S_IDLE: begin
                if (s_tvalid && s_tlast) state_next = ldr_pkg::S_BLD_CHK;
            end
            ldr_pkg::S_BLD_CHK: begin
                state_next = status.bld_more ? ldr_pkg::S_BLD_RD : ldr_pkg::S_EXT_CHK;
            end
            ldr_pkg::S_BLD_RD: state_next = ldr_pkg::S_BLD_V;
            ldr_pkg::S_BLD_V: begin
                state_next = ldr_pkg::S_DOWN;
                ret_next   = ldr_pkg::S_BLD_CHK;
            end
            ldr_pkg::S_DOWN: begin
                if (status.down_done) state_next = ret_reg;
            end
            ldr_pkg::S_EXT_CHK: begin
                state_next = status.size_gt1 ? ldr_pkg::S_EXT_RD : ldr_pkg::S_FIN_RD;
            end
            ldr_pkg::S_EXT_RD: state_next = ldr_pkg::S_EXT_V;
            ldr_pkg::S_EXT_V: begin
                state_next = ldr_pkg::S_DOWN;
                ret_next   = ldr_pkg::S_REP_RD;
            end
            ldr_pkg::S_REP_RD: state_next = ldr_pkg::S_REP_V;
            ldr_pkg::S_REP_V: begin
                state_next = ldr_pkg::S_DOWN;
                ret_next   = ldr_pkg::S_EXT_CHK;
            end
            ldr_pkg::S_FIN_RD: state_next = ldr_pkg::S_FIN_V;
            ldr_pkg::S_FIN_V: begin
                if (status.out_free) state_next = ldr_pkg::S_IDLE;
            end
            default: state_next = ldr_pkg::S_IDLE;
        endcase
    end

    // command and handshake outputs
    always_comb begin
        op       = ldr_pkg::OP_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            ldr_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) op = ldr_pkg::OP_LOAD;
            end
            ldr_pkg::S_BLD_RD: op = ldr_pkg::OP_BLD_RD;
            ldr_pkg::S_BLD_V:  op = ldr_pkg::OP_BLD_V;
            ldr_pkg::S_DOWN:   op = ldr_pkg::OP_DOWN;
            ldr_pkg::S_EXT_RD: op = ldr_pkg::OP_EXT_RD;
            ldr_pkg::S_EXT_V:  op = ldr_pkg::OP_EXT_V;
            ldr_pkg::S_REP_RD: op = ldr_pkg::OP_TOP_RD;
            ldr_pkg::S_REP_V:  op = ldr_pkg::OP_REP_V;
            ldr_pkg::S_FIN_RD: op = ldr_pkg::OP_TOP_RD;
            ldr_pkg::S_FIN_V: begin
                if (status.out_free) op = ldr_pkg::OP_OUT;
            end
            default: op = ldr_pkg::OP_NONE;
        endcase
    end

    // reset always lands in idle
    `LDR_ASSERT_RST(a_idle_after_reset, aclk, !aresetn |=> state_reg == ldr_pkg::S_IDLE, "controller not idle after reset")

endmodule

`default_nettype wire

FILE: sv/ldr_dpath.sv
// datapath: heap memory, sift-down unit, counters and output register
// depends on ldr_pkg and largest_differencing_residue_assert.svh
`default_nettype none
`include "largest_differencing_residue_assert.svh"

module ldr_dpath #(
    parameter int MAX_ITEMS  = ldr_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = ldr_pkg::DEF_VALUE_BITS,
    localparam int DW        = ((VALUE_BITS + 7) / 8) * 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire ldr_pkg::ldr_op_t op,
    input  wire logic [DW-1:0]   s_tdata,
    input  wire logic            s_tlast,
    input  wire logic            m_tready,
    output ldr_pkg::ldr_status_t status,
    output logic                 m_tvalid,
    output logic [DW-1:0]        m_tdata,
    output logic                 m_tuser
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = AW + 2;
    localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

    // heap store and its registered read ports
    logic [VALUE_BITS-1:0] heap_mem [MAX_ITEMS];
    logic [VALUE_BITS-1:0] rd0_reg, rd1_reg;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr, raddr0, raddr1;
    logic [VALUE_BITS-1:0] wr_data;

    // control registers
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] size_reg, size_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          m_valid_reg, m_valid_next;

    // payload registers
    logic [AW-1:0]         p_reg, p_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [VALUE_BITS-1:0] a_reg, a_next;
    logic [VALUE_BITS-1:0] res_reg, res_next;
    logic                  res_ovf_reg, res_ovf_next;
    logic                  end_ovf_reg, end_ovf_next;

    logic [VALUE_BITS-1:0] s_value;
    logic                  room;
    logic [CW-1:0]         cnt_inc, sz_new, size_m1, idx_m1;
    logic [XW-1:0]         size_x, p_lx, p_rx, c_lx, c_rx;
    logic                  p_lv, p_rv, l_gt_v, r_gt_v, r_gt_l, pick_r, move;
    logic [AW-1:0]         c_pos;
    logic [VALUE_BITS-1:0] child_val;

    // child address, parked at zero when outside the live heap
    function automatic logic [AW-1:0] kid_addr(input logic [XW-1:0] k,
                                               input logic [XW-1:0] lim);
        return (k < lim) ? k[AW-1:0] : '0;
    endfunction

    assign s_value = s_tdata[VALUE_BITS-1:0];
    assign room    = (count_reg != CAP);
    assign cnt_inc = count_reg + CW'(1);
    assign sz_new  = room ? cnt_inc : count_reg;
    assign size_m1 = size_reg - CW'(1);
    assign idx_m1  = idx_reg - CW'(1);

    // children of the current hole
    assign size_x = XW'(size_reg);
    assign p_lx   = XW'({p_reg, 1'b1});
    assign p_rx   = p_lx + XW'(1);
    assign p_lv   = p_lx < size_x;
    assign p_rv   = p_rx < size_x;

    // sift-down step: larger live child against the value being placed
    assign l_gt_v    = p_lv && (rd0_reg > v_reg);
    assign r_gt_v    = p_rv && (rd1_reg > v_reg);
    assign r_gt_l    = rd1_reg > rd0_reg;
    assign pick_r    = l_gt_v ? (p_rv && r_gt_l) : r_gt_v;
    assign move      = l_gt_v || r_gt_v;
    assign c_pos     = pick_r ? p_rx[AW-1:0] : p_lx[AW-1:0];
    assign child_val = pick_r ? rd1_reg : rd0_reg;
    assign c_lx      = XW'({c_pos, 1'b1});
    assign c_rx      = c_lx + XW'(1);

    // status towards the controller
    assign status.down_done = !move;
    assign status.bld_more  = (idx_reg != '0);
    assign status.size_gt1  = (size_reg > CW'(1));
    assign status.out_free  = !m_valid_reg || m_tready;

    // command decode
    always_comb begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        size_next    = size_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        p_next       = p_reg;
        v_next       = v_reg;
        a_next       = a_reg;
        res_next     = res_reg;
        res_ovf_next = res_ovf_reg;
        end_ovf_next = end_ovf_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = v_reg;
        raddr0       = '0;
        raddr1       = '0;
        unique case (op)
            ldr_pkg::OP_NONE: ;
            ldr_pkg::OP_LOAD: begin
                // store the number, or drop it once the heap is full
                if (room) begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[AW-1:0];
                    wr_data    = s_value;
                    count_next = cnt_inc;
                end else begin
                    ovf_next = 1'b1;
                end
                if (s_tlast) begin
                    size_next    = sz_new;
                    idx_next     = sz_new >> 1;
                    end_ovf_next = ovf_reg || !room;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                end
            end
            ldr_pkg::OP_BLD_RD: begin
                raddr0   = idx_m1[AW-1:0];
                p_next   = idx_m1[AW-1:0];
                idx_next = idx_m1;
            end
            ldr_pkg::OP_BLD_V: begin
                v_next = rd0_reg;
                raddr0 = kid_addr(p_lx, size_x);
                raddr1 = kid_addr(p_rx, size_x);
            end
            ldr_pkg::OP_EXT_RD: begin
                // fetch the top and the tail entry, heap shrinks by one
                raddr0    = '0;
                raddr1    = size_m1[AW-1:0];
                size_next = size_m1;
                p_next    = '0;
            end
            ldr_pkg::OP_EXT_V: begin
                a_next = rd0_reg;
                v_next = rd1_reg;
                raddr0 = kid_addr(p_lx, size_x);
                raddr1 = kid_addr(p_rx, size_x);
            end
            ldr_pkg::OP_TOP_RD: begin
                raddr0 = '0;
                p_next = '0;
            end
            ldr_pkg::OP_REP_V: begin
                // second largest is replaced by the difference in place
                v_next = a_reg - rd0_reg;
                raddr0 = kid_addr(p_lx, size_x);
                raddr1 = kid_addr(p_rx, size_x);
            end
            ldr_pkg::OP_DOWN: begin
                wr_en   = 1'b1;
                wr_addr = p_reg;
                if (move) begin
                    wr_data = child_val;
                    p_next  = c_pos;
                    raddr0  = kid_addr(c_lx, size_x);
                    raddr1  = kid_addr(c_rx, size_x);
                end else begin
                    wr_data = v_reg;
                end
            end
            ldr_pkg::OP_OUT: begin
                res_next     = rd0_reg;
                res_ovf_next = end_ovf_reg;
                m_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // heap memory, one write and two registered reads per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) heap_mem[wr_addr] <= wr_data;
        rd0_reg <= heap_mem[raddr0];
        rd1_reg <= heap_mem[raddr1];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            size_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            size_reg    <= size_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        v_reg       <= v_next;
        a_reg       <= a_next;
        res_reg     <= res_next;
        res_ovf_reg <= res_ovf_next;
        end_ovf_reg <= end_ovf_next;
    end

    // result request
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DW'(res_reg);
    assign m_tuser  = res_ovf_reg;

    `LDR_ASSERT(a_count_cap, aclk, aresetn, count_reg <= CAP, "entry count beyond capacity")
    `LDR_ASSERT(a_hole_live, aclk, aresetn, (op == ldr_pkg::OP_DOWN) |-> (XW'(p_reg) < size_x), "sift-down hole outside live heap")
    `LDR_ASSERT(a_diff_no_wrap, aclk, aresetn, (op == ldr_pkg::OP_REP_V) |-> (a_reg >= rd0_reg), "largest entry below second largest")
    `LDR_ASSERT(a_out_slot, aclk, aresetn, (op == ldr_pkg::OP_OUT) |-> (!m_valid_reg || m_tready), "result loaded over a pending one")

endmodule

`default_nettype wire

FILE: sv/largest_differencing_residue.sv
// load: one number per cycle while idle; after the last one the heap is built and
// reduced by sift-down passes that walk one level per step; a new set is accepted
// only once the last result is taken into the output register; the pace is set by
// the single heap memory (1 write, 2 reads)
// reset: synchronous, active low; clears controller, counts, overflow flag and
// result valid; the heap memory is not cleared
`default_nettype none

module largest_differencing_residue #(
    parameter int MAX_ITEMS  = ldr_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = ldr_pkg::DEF_VALUE_BITS,
    localparam int DW        = ((VALUE_BITS + 7) / 8) * 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [DW-1:0] s_tdata,   // value, zero padded
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [DW-1:0]      m_tdata,   // residue, zero padded
    output logic               m_tuser    // overflow
);

    ldr_pkg::ldr_op_t     op;
    ldr_pkg::ldr_status_t status;

    // sequencing
    ldr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    // heap store and arithmetic
    ldr_dpath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// self-checking bench for largest_differencing_residue: streams sets of numbers,
// predicts each residue and overflow flag, compares them with the result stream
// depends on ldr_pkg and the largest_differencing_residue top level
`default_nettype none

module tb_top;

    localparam int VB        = ldr_pkg::DEF_VALUE_BITS;
    localparam int CAPACITY  = ldr_pkg::DEF_MAX_ITEMS;
    localparam int DW        = ((VB + 7) / 8) * 8;
    localparam int NUM_ITEMS = 1850;
    localparam int LIMIT     = 1000000;
    localparam bit [VB-1:0] ALL_ONES = {VB{1'b1}};

    // predicted residues of completed sets, oldest first
    class residue_scoreboard;
        typedef struct {
            bit [VB-1:0] residue;
            bit          overflow;
        } residue_t;

        bit [VB-1:0] set_numbers[$];
        bit          dropped;
        residue_t    residues_due[$];
        int          errors;

        // repeatedly replace the two largest numbers by their difference
        function bit [VB-1:0] largest_difference(bit [VB-1:0] nums[$]);
            bit [VB-1:0] a;
            bit [VB-1:0] b;
            while (nums.size() > 1) begin
                nums.rsort();
                a = nums.pop_front();
                b = nums.pop_front();
                nums.push_back(a - b);
            end
            return (nums.size() == 0) ? '0 : nums[0];
        endfunction

        // accepted request: store the number, close the set on last
        function void note_number(bit [VB-1:0] v, bit last);
            residue_t r;
            if (set_numbers.size() < CAPACITY)
                set_numbers.push_back(v);
            else
                dropped = 1'b1;
            if (last) begin
                r.residue  = largest_difference(set_numbers);
                r.overflow = dropped;
                residues_due.push_back(r);
                set_numbers.delete();
                dropped = 1'b0;
            end
        endfunction

        // accepted result: compare with the oldest prediction
        function void check_residue(bit [VB-1:0] residue, bit overflow);
            residue_t r;
            if (residues_due.size() == 0) begin
                $display("%0t: unexpected result residue %h overflow %b",
                         $time, residue, overflow);
                errors++;
                return;
            end
            r = residues_due.pop_front();
            if (residue !== r.residue) begin
                $display("%0t: residue mismatch: expected %h actual %h",
                         $time, r.residue, residue);
                errors++;
            end
            if (overflow !== r.overflow) begin
                $display("%0t: overflow mismatch: expected %b actual %b",
                         $time, r.overflow, overflow);
                errors++;
            end
        endfunction

        function int pending();
            return residues_due.size();
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;
    logic          s_tlast;
    logic          m_tvalid;
    logic          m_tready;
    logic [DW-1:0] m_tdata;
    logic          m_tuser;

    residue_scoreboard board;
    bit                calm;
    int                sent_count;
    int                cycle_count;

    largest_differencing_residue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // value, zero padded
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // residue, zero padded
        .m_tuser  (m_tuser)     // overflow
    );

    // clock, period 8
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 18);
    end

    // watch both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_number(s_tdata[VB-1:0], s_tlast);
            if (m_tvalid && m_tready)
                board.check_residue(m_tdata[VB-1:0], m_tuser);
        end
    end

    // one number per request, with random gaps before it
    task automatic send_number(input bit [VB-1:0] v, input bit last);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DW'(v);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // numbers of mixed magnitude so every bit toggles
    function automatic bit [VB-1:0] random_number();
        bit [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return VB'($urandom_range(0, 15));
            1: return w[VB-1:0] >> $urandom_range(0, VB - 1);
            2: return ALL_ONES >> $urandom_range(0, 3);
            3: return '0;
            default: return w[VB-1:0];
        endcase
    endfunction

    initial begin
        bit [VB-1:0] edge_values[$];
        bit          edge_lasts[$];
        int          set_size;
        int          set_index;

        board      = new();
        calm       = 1'b0;
        sent_count = 0;
        cycle_count = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed sets: single numbers, extremes, ties, patterns, a textbook set
        edge_values = '{'0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '0,
                        VB'(1), VB'(1), VB'(1),
                        {(VB/2){2'b10}}, {(VB/2){2'b01}},
                        VB'(8), VB'(7), VB'(6), VB'(5), VB'(4),
                        VB'(1) << (VB - 1)};
        edge_lasts  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                        1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
        foreach (edge_values[i])
            send_number(edge_values[i], edge_lasts[i]);

        // hold off until every directed result is back
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);

        // random sets, mostly short, now and then around the store capacity
        set_index = 0;
        while (sent_count < NUM_ITEMS) begin
            calm = (set_index >= 25 && set_index < 45);
            if (set_index == 3 || $urandom_range(0, 29) == 0)
                set_size = $urandom_range(CAPACITY - 3, CAPACITY + 6);
            else
                set_size = $urandom_range(1, 16);
            for (int k = 0; k < set_size; k++)
                send_number(random_number(), k == set_size - 1);
            set_index++;
        end
        calm = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain, then watch for stray results
        while (board.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        board.errors += board.pending();

        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/ldr_pkg.sv
sv/ldr_ctrl.sv
sv/ldr_dpath.sv
sv/largest_differencing_residue.sv
sim/tb_top.sv
